>>> src/icf_pkg.sv
// ----------------------------------------------------------------------------
// icf_pkg
// shared codes and field widths of the inertial complementary filter
// ----------------------------------------------------------------------------
package icf_pkg;

    typedef enum logic [1:0] {
        KIND_PREDICT = 2'd0,
        KIND_HORIZ   = 2'd1,
        KIND_VERT    = 2'd2,
        KIND_LOAD    = 2'd3
    } t_kind;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_STEP_TIME = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY   = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WPOS_X    = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WPOS_Y    = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WPOS_Z    = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WVEL_X    = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_WVEL_Y    = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_WVEL_Z    = 4'd7;

    localparam logic [23:0] STEP_TIME_RST = 24'd41943;
    localparam logic [18:0] GRAVITY_RST   = 19'd40059;
    localparam logic [15:0] WPOS_XY_RST   = 16'd13107;
    localparam logic [15:0] WPOS_Z_RST    = 16'd6554;
    localparam logic [15:0] WVEL_XY_RST   = 16'd13107;
    localparam logic [15:0] WVEL_Z_RST    = 16'd3277;

    localparam int CHUNK_W = 12;

endpackage

>>> src/ins_complementary_filter.sv
// ----------------------------------------------------------------------------
// ins_complementary_filter
// position and velocity estimator on one shared multiply-accumulate unit
// ----------------------------------------------------------------------------
// channel   direction  handshake                       payload
// input     in         i_valid / o_stall               i_kind .. i_in_vel_z
// result    out        o_valid / i_stall               o_est_pos_x .. o_est_vel_z
// config    in         i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// from input transfer to result: predict rotates the acceleration and updates each enabled
// axis, horizontal correction blends x and y, vertical correction blends z, load copies
// the inputs; the sequencer returns to rest before the next transfer in
// all steps share the single 12-bit-chunk multiplier under its sequencer
// reset clears the state to zero and the registers to their defaults
// a result waiting on i_stall holds the sequencer at its last step; the next
// item is taken once the sequencer is back at rest
// ----------------------------------------------------------------------------
module ins_complementary_filter #(
    parameter int STATE_BITS    = 32,
    parameter int ROT_FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_kind,
    input  logic [47:0]        i_rot_row0,
    input  logic [47:0]        i_rot_row1,
    input  logic [47:0]        i_rot_row2,
    input  logic [59:0]        i_accel_body,
    input  logic [1:0]         i_axes_valid,
    input  logic signed [31:0] i_in_pos_x,
    input  logic signed [31:0] i_in_pos_y,
    input  logic signed [31:0] i_in_pos_z,
    input  logic signed [31:0] i_in_vel_x,
    input  logic signed [31:0] i_in_vel_y,
    input  logic signed [31:0] i_in_vel_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_est_pos_x,
    output logic signed [31:0] o_est_pos_y,
    output logic signed [31:0] o_est_pos_z,
    output logic signed [31:0] o_est_vel_x,
    output logic signed [31:0] o_est_vel_y,
    output logic signed [31:0] o_est_vel_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [icf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [icf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AW = (STATE_BITS + 1 > 34) ? STATE_BITS + 1 : 34;
    localparam int PW = AW + 17;
    localparam int WW = AW + 31;
    localparam int XW = AW + 3;
    localparam int CW = icf_pkg::CHUNK_W;

    localparam logic signed [WW-1:0] HALF_ROT = WW'(1) <<< (ROT_FRAC_BITS - 1);
    localparam logic signed [WW-1:0] HALF_16  = WW'(1) <<< 15;
    localparam logic signed [WW-1:0] HALF_24  = WW'(1) <<< 23;
    localparam logic signed [WW-1:0] HALF_25  = WW'(1) <<< 24;

    localparam logic signed [XW-1:0] SMAX = {{(XW-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
    localparam logic signed [XW-1:0] SMIN = ~SMAX;
    localparam logic signed [XW-1:0] OMAX = {{(XW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [XW-1:0] OMIN = ~OMAX;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_ROT, S_ROTFIN, S_H, S_HFIN, S_AXIS,
        S_MV, S_MVFIN, S_MPV, S_MPVFIN, S_MPH, S_MPHFIN,
        S_BP, S_BPFIN, S_BV, S_BVFIN, S_DONE
    } t_state;

    function automatic logic signed [STATE_BITS-1:0] f_sat(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] y;
        y = (x > SMAX) ? SMAX : ((x < SMIN) ? SMIN : x);
        return y[STATE_BITS-1:0];
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [STATE_BITS-1:0] s);
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        x = XW'(s);
        y = (x > OMAX) ? OMAX : ((x < OMIN) ? OMIN : x);
        return y[31:0];
    endfunction

    t_state r_state;
    logic [1:0] r_kind;
    logic [47:0] r_rot [3];
    logic [59:0] r_accel;
    logic [1:0]  r_axes;
    logic signed [31:0] r_mpos [3];
    logic signed [31:0] r_mvel [3];
    logic signed [STATE_BITS-1:0] r_pos [3];
    logic signed [STATE_BITS-1:0] r_vel [3];
    logic signed [AW-1:0] r_a16 [3];
    logic [23:0] r_h;
    logic signed [XW-1:0] r_tmp;
    logic signed [WW-1:0] r_acc;
    logic r_ph;
    logic [1:0] r_row;
    logic [1:0] r_col;
    logic [1:0] r_axis;

    logic [23:0] r_dt;
    logic [18:0] r_grav;
    logic [15:0] r_wpos [3];
    logic [15:0] r_wvel [3];

    logic signed [AW-1:0] op_a;
    logic [23:0]          op_k;
    logic signed [16:0]   op_b;
    logic signed [PW-1:0] prod;
    logic signed [WW-1:0] rsum;
    logic signed [XW-1:0] rnd;
    logic axis_on;
    logic axis_end;

    always_comb begin
        op_a = '0;
        op_k = '0;
        case (r_state)
            S_ROT: op_a = AW'($signed(r_accel[r_col*20 +: 20]));
            S_H:   begin
                op_a = AW'($signed({1'b0, r_dt}));
                op_k = r_dt;
            end
            S_MV:  begin
                op_a = r_a16[r_axis];
                op_k = r_dt;
            end
            S_MPV: begin
                op_a = AW'(r_vel[r_axis]);
                op_k = r_dt;
            end
            S_MPH: begin
                op_a = r_a16[r_axis];
                op_k = r_h;
            end
            S_BP:  begin
                op_a = AW'(r_mpos[r_axis]) - AW'(r_pos[r_axis]);
                op_k = {8'd0, r_wpos[r_axis]};
            end
            S_BV:  begin
                op_a = AW'(r_mvel[r_axis]) - AW'(r_vel[r_axis]);
                op_k = {8'd0, r_wvel[r_axis]};
            end
            default: op_a = '0;
        endcase
        if (r_state == S_ROT) begin
            op_b = 17'($signed(r_rot[r_row][r_col*16 +: 16]));
        end else begin
            op_b = $signed({5'd0, (r_ph ? op_k[2*CW-1:CW] : op_k[CW-1:0])});
        end
        prod = op_a * op_b;
    end

    always_comb begin
        case (r_state)
            S_ROTFIN: rsum = (r_acc + HALF_ROT) >>> ROT_FRAC_BITS;
            S_HFIN:   rsum = (r_acc + HALF_25) >>> 25;
            S_BPFIN, S_BVFIN: rsum = (r_acc + HALF_16) >>> 16;
            default:  rsum = (r_acc + HALF_24) >>> 24;
        endcase
        rnd = rsum[XW-1:0];
        axis_on  = (r_axis == 2'd2) ? r_axes[1] : r_axes[0];
        axis_end = (r_axis == 2'd3) ||
                   (r_kind == icf_pkg::KIND_HORIZ && r_axis == 2'd2);
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_ph    <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
            r_axis  <= '0;
            r_dt    <= icf_pkg::STEP_TIME_RST;
            r_grav  <= icf_pkg::GRAVITY_RST;
            r_wpos[0] <= icf_pkg::WPOS_XY_RST;
            r_wpos[1] <= icf_pkg::WPOS_XY_RST;
            r_wpos[2] <= icf_pkg::WPOS_Z_RST;
            r_wvel[0] <= icf_pkg::WVEL_XY_RST;
            r_wvel[1] <= icf_pkg::WVEL_XY_RST;
            r_wvel[2] <= icf_pkg::WVEL_Z_RST;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    icf_pkg::REG_STEP_TIME: r_dt      <= i_cfg_data;
                    icf_pkg::REG_GRAVITY:   r_grav    <= i_cfg_data[18:0];
                    icf_pkg::REG_WPOS_X:    r_wpos[0] <= i_cfg_data[15:0];
                    icf_pkg::REG_WPOS_Y:    r_wpos[1] <= i_cfg_data[15:0];
                    icf_pkg::REG_WPOS_Z:    r_wpos[2] <= i_cfg_data[15:0];
                    icf_pkg::REG_WVEL_X:    r_wvel[0] <= i_cfg_data[15:0];
                    icf_pkg::REG_WVEL_Y:    r_wvel[1] <= i_cfg_data[15:0];
                    icf_pkg::REG_WVEL_Z:    r_wvel[2] <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (o_valid && !i_stall && r_state != S_DONE) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind    <= i_kind;
                        r_rot[0]  <= i_rot_row0;
                        r_rot[1]  <= i_rot_row1;
                        r_rot[2]  <= i_rot_row2;
                        r_accel   <= i_accel_body;
                        r_axes    <= i_axes_valid;
                        r_mpos[0] <= i_in_pos_x;
                        r_mpos[1] <= i_in_pos_y;
                        r_mpos[2] <= i_in_pos_z;
                        r_mvel[0] <= i_in_vel_x;
                        r_mvel[1] <= i_in_vel_y;
                        r_mvel[2] <= i_in_vel_z;
                        r_row  <= '0;
                        r_col  <= '0;
                        r_ph   <= 1'b0;
                        r_axis <= (i_kind == icf_pkg::KIND_VERT) ? 2'd2 : 2'd0;
                        case (i_kind)
                            icf_pkg::KIND_PREDICT: r_state <= S_ROT;
                            icf_pkg::KIND_LOAD:    r_state <= S_LOAD;
                            default:               r_state <= S_AXIS;
                        endcase
                    end
                end
                S_LOAD: begin
                    for (int i = 0; i < 3; i++) begin
                        r_pos[i] <= f_sat(XW'(r_mpos[i]));
                        r_vel[i] <= f_sat(XW'(r_mvel[i]));
                    end
                    r_state <= S_DONE;
                end
                S_ROT: begin
                    r_acc <= (r_col == 2'd0) ? WW'(prod) : r_acc + WW'(prod);
                    if (r_col == 2'd2) begin
                        r_col   <= '0;
                        r_state <= S_ROTFIN;
                    end else begin
                        r_col <= r_col + 2'd1;
                    end
                end
                S_ROTFIN: begin
                    r_a16[r_row] <= AW'((rnd + ((r_row == 2'd2) ? XW'(r_grav) : XW'(0))) <<< 4);
                    if (r_row == 2'd2) begin
                        r_state <= S_H;
                    end else begin
                        r_row   <= r_row + 2'd1;
                        r_state <= S_ROT;
                    end
                end
                S_H, S_MV, S_MPV, S_MPH, S_BP, S_BV: begin
                    r_acc <= r_ph ? r_acc + (WW'(prod) <<< CW) : WW'(prod);
                    r_ph  <= ~r_ph;
                    if (r_ph) begin
                        case (r_state)
                            S_H:     r_state <= S_HFIN;
                            S_MV:    r_state <= S_MVFIN;
                            S_MPV:   r_state <= S_MPVFIN;
                            S_MPH:   r_state <= S_MPHFIN;
                            S_BP:    r_state <= S_BPFIN;
                            default: r_state <= S_BVFIN;
                        endcase
                    end
                end
                S_HFIN: begin
                    r_h     <= rnd[23:0];
                    r_state <= S_AXIS;
                end
                S_AXIS: begin
                    if (axis_end) begin
                        r_state <= S_DONE;
                    end else if (r_kind != icf_pkg::KIND_PREDICT) begin
                        r_state <= S_BP;
                    end else if (axis_on) begin
                        r_state <= S_MV;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                    end
                end
                S_MVFIN: begin
                    r_vel[r_axis] <= f_sat(XW'(r_vel[r_axis]) + rnd);
                    r_state       <= S_MPV;
                end
                S_MPVFIN: begin
                    r_tmp   <= rnd;
                    r_state <= S_MPH;
                end
                S_MPHFIN: begin
                    r_pos[r_axis] <= f_sat(XW'(r_pos[r_axis]) + r_tmp + rnd);
                    r_axis        <= r_axis + 2'd1;
                    r_state       <= S_AXIS;
                end
                S_BPFIN: begin
                    r_pos[r_axis] <= f_sat(XW'(r_pos[r_axis]) + rnd);
                    r_state       <= S_BV;
                end
                S_BVFIN: begin
                    r_vel[r_axis] <= f_sat(XW'(r_vel[r_axis]) + rnd);
                    r_axis        <= r_axis + 2'd1;
                    r_state       <= S_AXIS;
                end
                S_DONE: begin
                    if (!o_valid || !i_stall) begin
                        o_valid     <= 1'b1;
                        o_est_pos_x <= f_sat32(r_pos[0]);
                        o_est_pos_y <= f_sat32(r_pos[1]);
                        o_est_pos_z <= f_sat32(r_pos[2]);
                        o_est_vel_x <= f_sat32(r_vel[0]);
                        o_est_vel_y <= f_sat32(r_vel[1]);
                        o_est_vel_z <= f_sat32(r_vel[2]);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // a transfer in always starts the sequencer
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("sequencer did not start");

    // chunk phase is only ever set inside a multiply step
    a_phase_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ph |-> (r_state == S_H || r_state == S_MV || r_state == S_MPV ||
                  r_state == S_MPH || r_state == S_BP || r_state == S_BV))
        else $error("chunk phase outside multiply");

    // per-axis steps never run past the last axis
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MV || r_state == S_MPH || r_state == S_BP || r_state == S_BVFIN)
        |-> r_axis != 2'd3)
        else $error("axis counter out of range");

    // a pending result is never overwritten before its transfer
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall && r_state == S_DONE |=> r_state == S_DONE || !$past(i_stall))
        else $error("result overwritten");

endmodule

>>> test/ins_complementary_filter_tb.sv
// ----------------------------------------------------------------------------
// ins_complementary_filter_tb
// randomized self-checking bench: a fixed-point predictor tracks position and
// velocity and checks every estimate the filter returns, across several
// register settings and idle patterns
// ----------------------------------------------------------------------------
module ins_complementary_filter_tb;

    typedef struct {
        logic [1:0]         kind;
        logic [47:0]        row0, row1, row2;
        logic [59:0]        accel;
        logic [1:0]         axes;
        logic signed [31:0] mpos [3];
        logic signed [31:0] mvel [3];
    } t_item;

    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
    } t_estimate;

    class nav_scoreboard;
        longint pos [3];
        longint vel [3];
        longint unsigned step_time, gravity;
        longint unsigned wpos [3];
        longint unsigned wvel [3];
        t_estimate pending [$];
        int errors;

        function new();
            for (int i = 0; i < 3; i++) begin
                pos[i] = 0;
                vel[i] = 0;
            end
            step_time = icf_pkg::STEP_TIME_RST;
            gravity   = icf_pkg::GRAVITY_RST;
            wpos[0] = icf_pkg::WPOS_XY_RST;
            wpos[1] = icf_pkg::WPOS_XY_RST;
            wpos[2] = icf_pkg::WPOS_Z_RST;
            wvel[0] = icf_pkg::WVEL_XY_RST;
            wvel[1] = icf_pkg::WVEL_XY_RST;
            wvel[2] = icf_pkg::WVEL_Z_RST;
            errors = 0;
        endfunction

        function void write_reg(logic [icf_pkg::CFG_INDEX_W-1:0] idx,
                                logic [icf_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                icf_pkg::REG_STEP_TIME: step_time = data;
                icf_pkg::REG_GRAVITY:   gravity = data[18:0];
                icf_pkg::REG_WPOS_X:    wpos[0] = data[15:0];
                icf_pkg::REG_WPOS_Y:    wpos[1] = data[15:0];
                icf_pkg::REG_WPOS_Z:    wpos[2] = data[15:0];
                icf_pkg::REG_WVEL_X:    wvel[0] = data[15:0];
                icf_pkg::REG_WVEL_Y:    wvel[1] = data[15:0];
                icf_pkg::REG_WVEL_Z:    wvel[2] = data[15:0];
                default: ;
            endcase
        endfunction

        function longint clamp32(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        // floor(x * k / 2^sh + 1/2); x stays well within 128-bit range
        function longint scale_round(longint x, longint unsigned k, int sh);
            logic signed [127:0] p;
            p = $signed(128'(x)) * $signed({64'd0, k});
            p = p + (128'sd1 <<< (sh - 1));
            return longint'(p >>> sh);
        endfunction

        function void note_item(t_item it);
            t_estimate e;
            longint acc [3];
            longint a16 [3];
            longint sum, vn, pn;
            longint unsigned h;
            logic [47:0] rows [3];
            bit en;
            rows[0] = it.row0; rows[1] = it.row1; rows[2] = it.row2;
            case (icf_pkg::t_kind'(it.kind))
                icf_pkg::KIND_PREDICT: begin
                    h = (step_time * step_time + (64'd1 << 24)) >> 25;
                    for (int c = 0; c < 3; c++)
                        acc[c] = longint'($signed(it.accel[20*c +: 20]));
                    for (int r = 0; r < 3; r++) begin
                        sum = 0;
                        for (int c = 0; c < 3; c++)
                            sum += longint'($signed(rows[r][16*c +: 16])) * acc[c];
                        sum = (sum + (64'sd1 <<< 13)) >>> 14;
                        if (r == 2) sum += longint'(gravity);
                        a16[r] = sum * 16;
                    end
                    for (int r = 0; r < 3; r++) begin
                        en = (r < 2) ? it.axes[0] : it.axes[1];
                        if (en) begin
                            vn = clamp32(vel[r] + scale_round(a16[r], step_time, 24));
                            pn = pos[r] + scale_round(vn, step_time, 24)
                                 + scale_round(a16[r], h, 24);
                            vel[r] = vn;
                            pos[r] = clamp32(pn);
                        end
                    end
                end
                icf_pkg::KIND_HORIZ, icf_pkg::KIND_VERT: begin
                    for (int i = 0; i < 3; i++) begin
                        if ((i < 2) == (it.kind == icf_pkg::KIND_HORIZ)) begin
                            pos[i] = clamp32(pos[i] + scale_round(
                                longint'(it.mpos[i]) - pos[i], wpos[i], 16));
                            vel[i] = clamp32(vel[i] + scale_round(
                                longint'(it.mvel[i]) - vel[i], wvel[i], 16));
                        end
                    end
                end
                default: begin
                    for (int i = 0; i < 3; i++) begin
                        pos[i] = it.mpos[i];
                        vel[i] = it.mvel[i];
                    end
                end
            endcase
            for (int i = 0; i < 3; i++) begin
                e.pos[i] = pos[i][31:0];
                e.vel[i] = vel[i][31:0];
            end
            pending.push_back(e);
        endfunction

        function void check_estimate(t_estimate got);
            t_estimate w;
            string nm [3] = '{"x", "y", "z"};
            if (pending.size() == 0) begin
                $error("estimate with nothing expected");
                errors++;
                return;
            end
            w = pending.pop_front();
            for (int i = 0; i < 3; i++) begin
                if (got.pos[i] !== w.pos[i]) begin
                    $error("est_pos_%s expected %0d got %0d", nm[i], w.pos[i], got.pos[i]);
                    errors++;
                end
                if (got.vel[i] !== w.vel[i]) begin
                    $error("est_vel_%s expected %0d got %0d", nm[i], w.vel[i], got.vel[i]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, i_stall = 0;
    logic o_stall, o_valid, o_cfg_ready;
    logic [1:0] i_kind = 0, i_axes_valid = 0;
    logic [47:0] i_rot_row0 = 0, i_rot_row1 = 0, i_rot_row2 = 0;
    logic [59:0] i_accel_body = 0;
    logic signed [31:0] i_in_pos_x = 0, i_in_pos_y = 0, i_in_pos_z = 0;
    logic signed [31:0] i_in_vel_x = 0, i_in_vel_y = 0, i_in_vel_z = 0;
    logic signed [31:0] o_est_pos_x, o_est_pos_y, o_est_pos_z;
    logic signed [31:0] o_est_vel_x, o_est_vel_y, o_est_vel_z;
    logic i_cfg_valid = 0;
    logic [icf_pkg::CFG_INDEX_W-1:0] i_cfg_index = 0;
    logic [icf_pkg::CFG_DATA_W-1:0] i_cfg_data = 0;

    nav_scoreboard board = new();
    int send_idle = 0, recv_idle = 0;
    bit hold_off = 0;
    longint cycles = 0;

    ins_complementary_filter i_dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd3000000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver side: random stall, or a long hold-off when requested
    always @(posedge i_clk) begin
        t_estimate got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.pos[0] = o_est_pos_x; got.pos[1] = o_est_pos_y; got.pos[2] = o_est_pos_z;
            got.vel[0] = o_est_vel_x; got.vel[1] = o_est_vel_y; got.vel[2] = o_est_vel_z;
            board.check_estimate(got);
        end
        i_stall <= hold_off || ($urandom_range(99) < recv_idle);
    end

    function automatic logic [47:0] rand_row();
        case ($urandom_range(3))
            0: return 48'({$urandom, $urandom});
            1: return {16'($urandom_range(16384) - 8192), 16'($urandom_range(16384) - 8192),
                       16'($urandom_range(16384) - 8192)};
            2: return 48'h8000_8000_8000;
            default: return 48'h7FFF_7FFF_7FFF;
        endcase
    endfunction

    function automatic logic [31:0] rand_state();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(2000000)) - 32'd1000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item rand_item(logic [1:0] k);
        t_item it;
        it.kind = k;
        it.row0 = rand_row(); it.row1 = rand_row(); it.row2 = rand_row();
        it.accel = 60'({$urandom, $urandom});
        if ($urandom_range(1))
            it.accel = {20'($urandom_range(80000) - 40000), 20'($urandom_range(80000) - 40000),
                        20'($urandom_range(80000) - 40000)};
        it.axes = 2'($urandom_range(3));
        for (int i = 0; i < 3; i++) begin
            it.mpos[i] = rand_state();
            it.mvel[i] = rand_state();
        end
        return it;
    endfunction

    task automatic send_item(t_item it);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_kind <= it.kind;
        i_rot_row0 <= it.row0; i_rot_row1 <= it.row1; i_rot_row2 <= it.row2;
        i_accel_body <= it.accel; i_axes_valid <= it.axes;
        i_in_pos_x <= it.mpos[0]; i_in_pos_y <= it.mpos[1]; i_in_pos_z <= it.mpos[2];
        i_in_vel_x <= it.mvel[0]; i_in_vel_y <= it.mvel[1]; i_in_vel_z <= it.mvel[2];
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        board.note_item(it);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [icf_pkg::CFG_INDEX_W-1:0] idx,
                             logic [icf_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        board.write_reg(idx, data);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic write_all(logic [23:0] dt, logic [18:0] g, logic [15:0] wp,
                             logic [15:0] wv);
        write_reg(icf_pkg::REG_STEP_TIME, dt);
        write_reg(icf_pkg::REG_GRAVITY, {5'd0, g});
        write_reg(icf_pkg::REG_WPOS_X, {8'd0, wp});
        write_reg(icf_pkg::REG_WPOS_Y, 24'($urandom));
        write_reg(icf_pkg::REG_WPOS_Z, {8'd0, ~wp});
        write_reg(icf_pkg::REG_WVEL_X, {8'd0, wv});
        write_reg(icf_pkg::REG_WVEL_Y, 24'($urandom));
        write_reg(icf_pkg::REG_WVEL_Z, {8'd0, ~wv});
        write_reg(4'd8 + 4'($urandom_range(7)), 24'($urandom));
    endtask

    task automatic random_phase(int n);
        t_item it;
        for (int j = 0; j < n; j++) begin
            it = rand_item(2'($urandom_range(3)));
            if ($urandom_range(9) < 6) it.kind = icf_pkg::KIND_PREDICT;
            send_item(it);
        end
    endtask

    initial begin
        t_item it;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes and every kind
        for (int k = 0; k < 4; k++) begin
            it = rand_item(2'(k));
            it.axes = 2'b11;
            send_item(it);
        end
        it = rand_item(icf_pkg::KIND_LOAD);
        for (int i = 0; i < 3; i++) begin
            it.mpos[i] = 32'h7FFF_FFFF;
            it.mvel[i] = 32'h7FFF_FFFF;
        end
        send_item(it);
        it = rand_item(icf_pkg::KIND_PREDICT);
        it.row0 = 48'h7FFF_7FFF_7FFF; it.row1 = 48'h7FFF_7FFF_7FFF;
        it.row2 = 48'h7FFF_7FFF_7FFF;
        it.accel = {3{20'h7FFFF}}; it.axes = 2'b11;
        send_item(it);
        it.row0 = 48'h8000_8000_8000; it.row1 = it.row0; it.row2 = it.row0;
        it.accel = {3{20'h80000}};
        send_item(it);
        for (int a = 0; a < 4; a++) begin
            it = rand_item(icf_pkg::KIND_PREDICT);
            it.axes = 2'(a);
            send_item(it);
        end
        it = rand_item(icf_pkg::KIND_LOAD);
        for (int i = 0; i < 3; i++) begin
            it.mpos[i] = 32'h8000_0000;
            it.mvel[i] = 32'h8000_0000;
        end
        send_item(it);
        send_item(rand_item(icf_pkg::KIND_HORIZ));
        send_item(rand_item(icf_pkg::KIND_VERT));
        drain();

        write_all(24'hFFFFFF, 19'h7FFFF, 16'hFFFF, 16'hFFFF);
        send_idle = 38; recv_idle = 84;
        random_phase(300);
        drain();

        write_all(24'd0, 19'd0, 16'd0, 16'd0);
        send_idle = 84; recv_idle = 38;
        random_phase(250);
        drain();

        write_all(24'($urandom_range(200000)), 19'($urandom_range(524287)), 16'($urandom),
                  16'($urandom));
        send_idle = 0; recv_idle = 0;
        random_phase(300);

        // long receiver hold-off while items keep coming
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            begin
                random_phase(20);
                drain();
            end
        join

        write_all(24'd41943, 19'd40059, 16'($urandom), 16'($urandom));
        send_idle = 10; recv_idle = 10;
        random_phase(460);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
